// ===== rtl/core/rfn_pkg.sv =====
// Shared types, request and status codes for the rANS frequency normalizer.
`default_nettype none
package rfn_pkg;

  // Data widths fixed by the word format.
  localparam int DATA_W = 32;
  localparam int TGT_W  = 17;
  localparam int DVS_W  = 32;
  localparam int DVD_W  = TGT_W + DVS_W;

  // Request kinds carried in the input tuser.
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_COUNT = 2'd1;
  localparam logic [1:0] REQ_NORM  = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Result status codes carried in the output tuser.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NO_DONOR  = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd3;

  // Status reported by the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/rfn_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module rfn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/rfn_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none
module rfn_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [rfn_pkg::DVD_W-1:0]   dividend,
  input  wire logic [rfn_pkg::DVS_W-1:0]   divisor,
  output logic      [rfn_pkg::DVS_W-1:0]   quotient,
  output rfn_pkg::div_status_t             status
);

  localparam int CNT_W = $clog2(rfn_pkg::DVD_W + 1);

  logic [rfn_pkg::DVS_W-1:0] rem;
  logic [rfn_pkg::DVD_W-1:0] quo;
  logic [rfn_pkg::DVS_W-1:0] dvs;
  logic [CNT_W-1:0]          cnt;
  logic [rfn_pkg::DVS_W:0]   rem_sh;
  logic                      fits;

  // One shift-and-subtract step.
  assign rem_sh = {rem, quo[rfn_pkg::DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};
  assign quotient = quo[rfn_pkg::DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      // Done pulses for one cycle after the last step.
      status.done <= !start && status.busy && (cnt == CNT_W'(1));
      if (start) begin
        status.busy <= 1'b1;
        cnt         <= CNT_W'(rfn_pkg::DVD_W);
        quo         <= dividend;
        dvs         <= divisor;
        rem         <= '0;
      end else if (status.busy) begin
        if (fits) begin
          rem <= rfn_pkg::DVS_W'(rem_sh - {1'b0, dvs});
        end else begin
          rem <= rem_sh[rfn_pkg::DVS_W-1:0];
        end
        quo <= {quo[rfn_pkg::DVD_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          status.busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rans_frequency_normalizer.sv =====
// Top level: byte histogram and rANS frequency normalizer around three RAMs.
//
//  Channel  Direction  Word contents
//  s_*      in         tuser: req_type; tdata: symbol, read_index
//  m_*      out        tuser: status; tdata: freq, cum_freq
//  cfg_*    in         cfg_data: target_total
//
// A count does a read-modify-write of the count memory; a read passes through a wait
// state and the result state before its word is offered. Clear works on per-entry valid
// bits. Normalize builds prefix sums of the counts, rescales each boundary with the
// bit-serial divider, repairs empty ranges of present symbols by shifting boundaries and
// commits the tables. Reset is synchronous and needs no clearing pass. A result waits in
// the output register while the next word is taken.
`default_nettype none
module rans_frequency_normalizer #(
  parameter int NUM_SYMBOLS = 256,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // symbol[7:0], read_index[16:8], zero fill
  input  wire logic [1:0]  s_tuser,   // req_type[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [63:0] m_tdata,   // freq[31:0], cum_freq[63:32]
  output logic      [1:0]  m_tuser,   // status[1:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_data   // target_total[16:0]
);

  localparam int SW = $clog2(NUM_SYMBOLS);
  localparam int CW = $clog2(NUM_SYMBOLS + 1);
  localparam int DW = rfn_pkg::DATA_W;
  localparam logic [DW-1:0] COUNT_MAX = 32'hFFFF_FFFF >> (32 - COUNT_BITS);
  localparam logic [CW-1:0] IDX_N  = CW'(NUM_SYMBOLS);
  localparam logic [CW-1:0] IDX_LS = CW'(NUM_SYMBOLS - 1);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_CNT_WR = 5'd1;
  localparam logic [4:0] ST_RD_WT  = 5'd2;
  localparam logic [4:0] ST_RES    = 5'd3;
  localparam logic [4:0] ST_P_INIT = 5'd4;
  localparam logic [4:0] ST_P_RD   = 5'd5;
  localparam logic [4:0] ST_P_WR   = 5'd6;
  localparam logic [4:0] ST_P_CHK  = 5'd7;
  localparam logic [4:0] ST_S_RD   = 5'd8;
  localparam logic [4:0] ST_S_MUL  = 5'd9;
  localparam logic [4:0] ST_S_GO   = 5'd10;
  localparam logic [4:0] ST_S_DIV  = 5'd11;
  localparam logic [4:0] ST_R_RD0  = 5'd12;
  localparam logic [4:0] ST_R_RD1  = 5'd13;
  localparam logic [4:0] ST_R_CHK  = 5'd14;
  localparam logic [4:0] ST_F_INIT = 5'd15;
  localparam logic [4:0] ST_F_STEP = 5'd16;
  localparam logic [4:0] ST_A_INIT = 5'd17;
  localparam logic [4:0] ST_A_RD   = 5'd18;
  localparam logic [4:0] ST_A_WR   = 5'd19;
  localparam logic [4:0] ST_C_INIT = 5'd20;
  localparam logic [4:0] ST_C_STEP = 5'd21;

  logic [4:0]    state;
  logic [16:0]   target;
  logic [DW-1:0] total_count;
  logic          overflow;
  logic [NUM_SYMBOLS-1:0] valid;
  logic          vq;

  logic [CW-1:0] idx, sidx, best, hi, idx_m1;
  logic [SW-1:0] cnt_sym;
  logic          dir_dn, found, fzero, rd_fok, rd_cok;
  logic [DW-1:0] acc, prev, cmp_a, best_w, curr, w_diff;
  logic [rfn_pkg::DVD_W-1:0] prod;
  logic          cand;

  logic [1:0]    res_status;
  logic [DW-1:0] res_freq, res_cum;

  // Memory ports.
  logic          f_we, w_we, c_we;
  logic [SW-1:0] f_waddr, f_raddr;
  logic [CW-1:0] w_waddr, w_raddr, c_waddr, c_raddr;
  logic [DW-1:0] f_wdata, f_rdata, w_wdata, w_rdata, c_wdata, c_rdata, fval;

  logic [DW-1:0]        quot;
  rfn_pkg::div_status_t div_st;

  logic          accept;
  logic [7:0]    in_sym;
  logic [8:0]    in_idx;
  logic          sym_ok;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_sym   = s_tdata[7:0];
  assign in_idx   = s_tdata[16:8];
  assign sym_ok   = 32'(in_sym) < NUM_SYMBOLS;
  assign fval     = vq ? f_rdata : '0;
  assign idx_m1   = idx - CW'(1);
  assign w_diff   = w_rdata - prev;
  assign cand     = (idx != '0) && (w_diff > DW'(1)) && (w_diff < best_w);

  // Count memory, work memory and cumulative table.
  rfn_ram #(.WIDTH(DW), .DEPTH(NUM_SYMBOLS)) u_freq (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );
  rfn_ram #(.WIDTH(DW), .DEPTH(NUM_SYMBOLS + 1)) u_work (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rdata)
  );
  rfn_ram #(.WIDTH(DW), .DEPTH(NUM_SYMBOLS + 1)) u_cum (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata)
  );

  rfn_div u_div (
    .clk, .rst, .start(state == ST_S_GO), .dividend(prod), .divisor(curr),
    .quotient(quot), .status(div_st)
  );

  // Memory address and write control per state.
  always_comb begin
    f_we = 1'b0; f_waddr = cnt_sym; f_wdata = fval + DW'(1);
    f_raddr = idx[SW-1:0];
    w_we = 1'b0; w_waddr = idx; w_wdata = '0; w_raddr = idx;
    c_we = 1'b0; c_waddr = idx; c_wdata = w_rdata;
    c_raddr = in_idx[CW-1:0];
    unique case (state)
      ST_IDLE: begin
        f_raddr = (s_tuser == rfn_pkg::REQ_READ) ? in_idx[SW-1:0] : in_sym[SW-1:0];
      end
      ST_CNT_WR: f_we = 1'b1;
      ST_P_INIT: begin
        w_we = 1'b1; w_waddr = '0;
      end
      ST_P_WR: begin
        w_we = 1'b1; w_waddr = idx + CW'(1); w_wdata = acc + fval;
      end
      ST_S_DIV: begin
        w_we = div_st.done; w_wdata = quot;
      end
      ST_R_RD0: begin
        f_raddr = sidx[SW-1:0]; w_raddr = sidx;
      end
      ST_R_RD1: w_raddr = sidx + CW'(1);
      ST_F_INIT, ST_C_INIT: w_raddr = '0;
      ST_F_STEP: w_raddr = idx + CW'(1);
      ST_A_WR: begin
        w_we = 1'b1;
        w_wdata = dir_dn ? w_rdata - DW'(1) : w_rdata + DW'(1);
      end
      ST_C_STEP: begin
        w_raddr = idx + CW'(1);
        c_we = 1'b1;
        f_we = (idx != '0); f_waddr = idx_m1[SW-1:0]; f_wdata = w_rdata - prev;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and state registers.
  always_ff @(posedge clk) begin
    vq <= valid[f_raddr];
    if (rst) begin
      state       <= ST_IDLE;
      target      <= 17'd4096;
      total_count <= '0;
      overflow    <= 1'b0;
      valid       <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        target <= cfg_data;
      end
      // Result register: load from the result state, drop once taken.
      if (state == ST_RES && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (f_we) begin
        valid[f_waddr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          res_freq <= '0;
          res_cum  <= '0;
          if (accept) begin
            unique case (s_tuser)
              rfn_pkg::REQ_CLEAR: begin
                valid <= '0; total_count <= '0; overflow <= 1'b0;
              end
              rfn_pkg::REQ_COUNT: begin
                if (sym_ok) begin
                  if (overflow || total_count >= COUNT_MAX) begin
                    overflow   <= 1'b1;
                    res_status <= rfn_pkg::STAT_OVERFLOW;
                    state      <= ST_RES;
                  end else begin
                    cnt_sym <= in_sym[SW-1:0];
                    state   <= ST_CNT_WR;
                  end
                end
              end
              rfn_pkg::REQ_NORM: begin
                if (overflow) begin
                  res_status <= rfn_pkg::STAT_OVERFLOW; state <= ST_RES;
                end else if (total_count == '0) begin
                  res_status <= rfn_pkg::STAT_EMPTY; state <= ST_RES;
                end else begin
                  state <= ST_P_INIT;
                end
              end
              default: begin
                rd_fok <= 32'(in_idx) < NUM_SYMBOLS;
                rd_cok <= 32'(in_idx) <= NUM_SYMBOLS;
                state  <= ST_RD_WT;
              end
            endcase
          end
        end
        ST_CNT_WR: begin
          total_count <= total_count + DW'(1);
          state       <= ST_IDLE;
        end
        ST_RD_WT: begin
          res_status <= rfn_pkg::STAT_OK;
          res_freq   <= rd_fok ? fval : '0;
          res_cum    <= rd_cok ? c_rdata : '0;
          state      <= ST_RES;
        end
        ST_RES: begin
          if (!m_tvalid || m_tready) begin
            m_tuser  <= res_status;
            m_tdata  <= {res_cum, res_freq};
            state    <= ST_IDLE;
          end
        end
        // Prefix sums of the counts into the work memory.
        ST_P_INIT: begin
          acc <= '0; idx <= '0; state <= ST_P_RD;
        end
        ST_P_RD: state <= ST_P_WR;
        ST_P_WR: begin
          acc <= acc + fval;
          if (idx == IDX_LS) begin
            state <= ST_P_CHK;
          end else begin
            idx <= idx + CW'(1); state <= ST_P_RD;
          end
        end
        ST_P_CHK: begin
          curr <= acc;
          if (acc == '0) begin
            res_status <= rfn_pkg::STAT_EMPTY; state <= ST_RES;
          end else begin
            idx <= CW'(1); state <= ST_S_RD;
          end
        end
        // Rescale each boundary to the target total.
        ST_S_RD:  state <= ST_S_MUL;
        ST_S_MUL: begin
          prod  <= {32'b0, target} * {17'b0, w_rdata};
          state <= ST_S_GO;
        end
        ST_S_GO:  state <= ST_S_DIV;
        ST_S_DIV: begin
          if (div_st.done) begin
            if (idx == IDX_N) begin
              sidx <= '0; state <= ST_R_RD0;
            end else begin
              idx <= idx + CW'(1); state <= ST_S_RD;
            end
          end
        end
        // Look for a present symbol whose range is empty.
        ST_R_RD0: state <= ST_R_RD1;
        ST_R_RD1: begin
          fzero <= (fval == '0); cmp_a <= w_rdata; state <= ST_R_CHK;
        end
        ST_R_CHK: begin
          if (fzero || cmp_a != w_rdata) begin
            state <= (sidx == IDX_LS) ? ST_C_INIT : ST_R_RD0;
            sidx  <= sidx + CW'(1);
          end else begin
            idx <= '0; best_w <= '1; found <= 1'b0; state <= ST_F_INIT;
          end
        end
        // Scan for the narrowest range wider than one; lowest index wins a tie.
        ST_F_INIT: state <= ST_F_STEP;
        ST_F_STEP: begin
          prev <= w_rdata;
          if (cand) begin
            best_w <= w_diff; best <= idx_m1; found <= 1'b1;
          end
          if (idx == IDX_N) begin
            if (!(found || cand)) begin
              res_status <= rfn_pkg::STAT_NO_DONOR; state <= ST_RES;
            end else begin
              state <= ST_A_INIT;
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
        // Shift the boundaries between donor and receiver by one.
        ST_A_INIT: begin
          if (best < sidx) begin
            dir_dn <= 1'b1; idx <= best + CW'(1); hi <= sidx;
          end else begin
            dir_dn <= 1'b0; idx <= sidx + CW'(1); hi <= best;
          end
          state <= ST_A_RD;
        end
        ST_A_RD: state <= ST_A_WR;
        ST_A_WR: begin
          if (idx == hi) begin
            state <= (sidx == IDX_LS) ? ST_C_INIT : ST_R_RD0;
            sidx  <= sidx + CW'(1);
          end else begin
            idx <= idx + CW'(1); state <= ST_A_RD;
          end
        end
        // Commit the work table into the cumulative and count memories.
        ST_C_INIT: begin
          idx <= '0; state <= ST_C_STEP;
        end
        ST_C_STEP: begin
          prev <= w_rdata;
          if (idx == IDX_N) begin
            total_count <= w_rdata;
            res_status  <= rfn_pkg::STAT_OK;
            state       <= ST_RES;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rfn_checker.sv =====
// Port-level checks for the normalizer and the bind that attaches them.
`default_nettype none
module rfn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Error results carry zero data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != rfn_pkg::STAT_OK |-> m_tdata == '0)
    else $error("error result with nonzero data");

  // Normalize and read requests keep the block busy after they are accepted.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == rfn_pkg::REQ_NORM || s_tuser == rfn_pkg::REQ_READ)
    |=> !s_tready)
    else $error("block ready right after normalize or read");

  // A clear produces no result.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == rfn_pkg::REQ_CLEAR && !m_tvalid |=> !m_tvalid)
    else $error("clear produced a result");

endmodule

bind rans_frequency_normalizer rfn_checker u_rfn_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
